// ----- hw/rtl/sqrt_continued_fraction_terms_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the square-root continued-fraction term unit.
// Each macro checks a property on the rising edge of clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef SQRT_CONTINUED_FRACTION_TERMS_UNIT_DEFINES_SVH
`define SQRT_CONTINUED_FRACTION_TERMS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define SCFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never becomes true outside reset.
`define SCFT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SCFT_ASSERT(lbl, prop, msg)
`define SCFT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- hw/rtl/scft_pkg.sv -----
// ----------------------------------------------------------------------------
// scft_pkg
// Widths, command codes and interface structs shared by the term unit.
// ----------------------------------------------------------------------------
package scft_pkg;

  localparam int RAD_W      = 32;
  localparam int CFG_W      = 32;
  localparam int TERM_W     = 17;
  localparam int SQ_STEPS   = (RAD_W + 1) / 2;
  localparam int ROOT_W     = SQ_STEPS;
  localparam int VAL_W      = ROOT_W + 1;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int SRC_W      = 2 * SQ_STEPS;
  localparam int SQ_REM_W   = ROOT_W + 1;
  localparam int SQ_ACC_W   = ROOT_W + 3;
  localparam int SQ_CNT_W   = $clog2(SQ_STEPS + 1);
  localparam int DIV_CNT_W  = $clog2(RAD_W + 1);
  localparam int DIV2_BITS  = VAL_W + 1;
  localparam int DIV2_SHIFT = RAD_W - DIV2_BITS;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQRT_GO,
    OP_WHOLE_LOAD,
    OP_WRAP,
    OP_MUL_DA,
    OP_SUB_M,
    OP_MUL_MM,
    OP_DIV1_GO,
    OP_DIV2_GO,
    OP_COMMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_WHOLE,
    RES_TERM,
    RES_ERR
  } res_kind_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sq;
    logic d_zero;
    logic d_one;
    logic m_zero;
    logic sqrt_done;
    logic div_done;
    logic div_busy;
    logic q_zero;
  } dp_stat_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [VAL_W-1:0]  last_term;
    logic              d_one;
    logic              sq;
  } dp_view_t;

  typedef struct packed {
    logic      emit;
    res_kind_t kind;
  } ctl_res_t;

endpackage

// ----- hw/rtl/scft_div.sv -----
// ----------------------------------------------------------------------------
// scft_div
// Radix-2 restoring divider, one quotient bit per cycle, variable bit count.
// ----------------------------------------------------------------------------
module scft_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [scft_pkg::DIV_CNT_W-1:0]  nbits,
  input  logic [scft_pkg::RAD_W-1:0]      dividend,
  input  logic [scft_pkg::VAL_W-1:0]      divisor,
  output logic [scft_pkg::RAD_W-1:0]      quotient,
  output logic                            done,
  output logic                            busy
);

  logic [scft_pkg::DIV_CNT_W-1:0] cnt;
  logic [scft_pkg::RAD_W-1:0]     dvd;
  logic [scft_pkg::VAL_W-1:0]     rem;
  logic [scft_pkg::VAL_W-1:0]     dsr;
  logic [scft_pkg::VAL_W:0]       shifted;
  logic [scft_pkg::VAL_W:0]       diff;
  logic                           ge;

  // The dividend register shifts out its top bit and takes in quotient bits.
  always_comb begin
    shifted = {rem, dvd[scft_pkg::RAD_W-1]};
    ge      = shifted >= {1'b0, dsr};
    diff    = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= nbits;
        dvd <= dividend;
        rem <= '0;
        dsr <= divisor;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == scft_pkg::DIV_CNT_W'(1));
        rem  <= ge ? diff[scft_pkg::VAL_W-1:0] : shifted[scft_pkg::VAL_W-1:0];
        dvd  <= {dvd[scft_pkg::RAD_W-2:0], ge};
      end
    end
  end

  assign quotient = dvd;
  assign busy     = (cnt != '0);

endmodule

// ----- hw/rtl/scft_datapath.sv -----
// ----------------------------------------------------------------------------
// scft_datapath
// Radicand, expansion state, integer square root, multiplier and divider.
// ----------------------------------------------------------------------------
module scft_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scft_pkg::CFG_W-1:0]  cfg_data,
  input  scft_pkg::dp_cmd_t           cmd,
  output scft_pkg::dp_stat_t          stat,
  output scft_pkg::dp_view_t          view
);

  logic [scft_pkg::RAD_W-1:0]    rad;
  logic [scft_pkg::ROOT_W-1:0]   root;
  logic                          sq;
  logic [scft_pkg::VAL_W-1:0]    offset_m;
  logic [scft_pkg::VAL_W-1:0]    denom_d;
  logic [scft_pkg::VAL_W-1:0]    last_term;
  logic [scft_pkg::VAL_W-1:0]    first_m;
  logic [scft_pkg::VAL_W-1:0]    first_d;
  logic [scft_pkg::VAL_W-1:0]    first_term;
  logic [scft_pkg::PROD_W-1:0]   prod;
  logic [scft_pkg::VAL_W-1:0]    m_new;
  logic [scft_pkg::VAL_W-1:0]    d_new;

  // Digit-by-digit square root state.
  logic [scft_pkg::SRC_W-1:0]    sq_src;
  logic [scft_pkg::SQ_REM_W-1:0] sq_rem;
  logic [scft_pkg::ROOT_W-1:0]   sq_root;
  logic [scft_pkg::SQ_CNT_W-1:0] sq_cnt;
  logic                          sq_done;
  logic [scft_pkg::SQ_ACC_W-1:0] sq_acc;
  logic [scft_pkg::SQ_ACC_W-1:0] sq_trial;
  logic                          sq_ge;

  // Divider hookup.
  logic                           div_start;
  logic [scft_pkg::DIV_CNT_W-1:0] div_nbits;
  logic [scft_pkg::RAD_W-1:0]     div_dividend;
  logic [scft_pkg::VAL_W-1:0]     div_divisor;
  logic [scft_pkg::RAD_W-1:0]     div_q;
  logic                           div_done;
  logic                           div_busy;
  logic [scft_pkg::PROD_W-1:0]    num1;
  logic [scft_pkg::DIV2_BITS-1:0] num2;
  logic [scft_pkg::VAL_W-1:0]     q_val;

  always_comb begin
    sq_acc   = {sq_rem, sq_src[scft_pkg::SRC_W-1 -: 2]};
    sq_trial = {1'b0, sq_root, 2'b01};
    sq_ge    = sq_acc >= sq_trial;
  end

  always_comb begin
    num1  = scft_pkg::PROD_W'(rad) - prod;
    num2  = scft_pkg::DIV2_BITS'(root) + scft_pkg::DIV2_BITS'(m_new);
    q_val = scft_pkg::VAL_W'(div_q);
    div_start    = 1'b0;
    div_nbits    = scft_pkg::DIV_CNT_W'(scft_pkg::RAD_W);
    div_dividend = scft_pkg::RAD_W'(num1);
    div_divisor  = denom_d;
    unique case (cmd.op)
      scft_pkg::OP_DIV1_GO: begin
        div_start = 1'b1;
      end
      scft_pkg::OP_DIV2_GO: begin
        div_start    = 1'b1;
        div_nbits    = scft_pkg::DIV_CNT_W'(scft_pkg::DIV2_BITS);
        div_dividend = scft_pkg::RAD_W'(num2) << scft_pkg::DIV2_SHIFT;
        div_divisor  = q_val;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  scft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .nbits    (div_nbits),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done),
    .busy     (div_busy)
  );

  // Square root unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt  <= '0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.op == scft_pkg::OP_SQRT_GO) begin
        sq_cnt  <= scft_pkg::SQ_CNT_W'(scft_pkg::SQ_STEPS);
        sq_src  <= scft_pkg::SRC_W'(rad);
        sq_rem  <= '0;
        sq_root <= '0;
      end else if (sq_cnt != '0) begin
        sq_cnt  <= sq_cnt - 1'b1;
        sq_done <= (sq_cnt == scft_pkg::SQ_CNT_W'(1));
        sq_src  <= sq_src << 2;
        sq_rem  <= sq_ge ? scft_pkg::SQ_REM_W'(sq_acc - sq_trial)
                         : scft_pkg::SQ_REM_W'(sq_acc);
        sq_root <= {sq_root[scft_pkg::ROOT_W-2:0], sq_ge};
      end
    end
  end

  // Expansion state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rad        <= scft_pkg::RAD_W'(2);
      root       <= '0;
      sq         <= 1'b0;
      offset_m   <= '0;
      denom_d    <= scft_pkg::VAL_W'(1);
      last_term  <= '0;
      first_m    <= '0;
      first_d    <= scft_pkg::VAL_W'(1);
      first_term <= '0;
    end else begin
      if (cfg_we) begin
        rad <= scft_pkg::RAD_W'(cfg_data);
      end
      unique case (cmd.op)
        scft_pkg::OP_WHOLE_LOAD: begin
          root      <= sq_root;
          sq        <= (sq_rem == '0);
          offset_m  <= '0;
          denom_d   <= scft_pkg::VAL_W'(1);
          last_term <= scft_pkg::VAL_W'(sq_root);
        end
        scft_pkg::OP_WRAP: begin
          offset_m  <= first_m;
          denom_d   <= first_d;
          last_term <= first_term;
        end
        scft_pkg::OP_COMMIT: begin
          offset_m  <= m_new;
          denom_d   <= d_new;
          last_term <= q_val;
          if (offset_m == '0) begin
            first_m    <= m_new;
            first_d    <= d_new;
            first_term <= q_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Product and intermediate registers; each product is registered before use.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      scft_pkg::OP_MUL_DA: prod  <= denom_d * last_term;
      scft_pkg::OP_SUB_M:  m_new <= scft_pkg::VAL_W'(prod - scft_pkg::PROD_W'(offset_m));
      scft_pkg::OP_MUL_MM: prod  <= m_new * m_new;
      scft_pkg::OP_DIV2_GO: d_new <= q_val;
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.sq        = sq;
    stat.d_zero    = (denom_d == '0);
    stat.d_one     = (denom_d == scft_pkg::VAL_W'(1));
    stat.m_zero    = (offset_m == '0);
    stat.sqrt_done = sq_done;
    stat.div_done  = div_done;
    stat.div_busy  = div_busy;
    stat.q_zero    = (div_q == '0);
    view.root      = root;
    view.last_term = last_term;
    view.d_one     = (denom_d == scft_pkg::VAL_W'(1));
    view.sq        = sq;
  end

endmodule

// ----- hw/rtl/scft_ctrl.sv -----
// ----------------------------------------------------------------------------
// scft_ctrl
// Sequencer: takes an item, steps the datapath and hands off one result.
// ----------------------------------------------------------------------------
`include "sqrt_continued_fraction_terms_unit_defines.svh"

module scft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  input  logic                out_free,
  input  scft_pkg::dp_stat_t  stat,
  output scft_pkg::dp_cmd_t   cmd,
  output scft_pkg::ctl_res_t  res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_WHOLE,
    S_WRAP,
    S_MUL_DA,
    S_SUB_M,
    S_MUL_MM,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV1_TAKE,
    S_DIV2_WAIT,
    S_COMMIT,
    S_EMIT
  } state_t;

  state_t              state;
  logic                started;
  scft_pkg::res_kind_t kind;
  logic                accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op = scft_pkg::OP_NONE;
    unique case (state)
      S_SQRT_GO: cmd.op = scft_pkg::OP_SQRT_GO;
      S_WHOLE:   cmd.op = scft_pkg::OP_WHOLE_LOAD;
      S_WRAP:    cmd.op = scft_pkg::OP_WRAP;
      S_MUL_DA:  cmd.op = scft_pkg::OP_MUL_DA;
      S_SUB_M:   cmd.op = scft_pkg::OP_SUB_M;
      S_MUL_MM:  cmd.op = scft_pkg::OP_MUL_MM;
      S_DIV1_GO: cmd.op = scft_pkg::OP_DIV1_GO;
      S_DIV1_TAKE: begin
        if (!stat.q_zero) begin
          cmd.op = scft_pkg::OP_DIV2_GO;
        end
      end
      S_COMMIT:  cmd.op = scft_pkg::OP_COMMIT;
      default:   cmd.op = scft_pkg::OP_NONE;
    endcase
    res.emit = (state == S_EMIT) && out_free;
    res.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
      kind    <= scft_pkg::RES_TERM;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (restart || !started) begin
              state <= S_SQRT_GO;
            end else if (stat.sq || stat.d_zero) begin
              kind  <= scft_pkg::RES_ERR;
              state <= S_EMIT;
            end else if (stat.d_one && !stat.m_zero) begin
              state <= S_WRAP;
            end else begin
              state <= S_MUL_DA;
            end
          end
        end
        S_SQRT_GO:   state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (stat.sqrt_done) begin
            state <= S_WHOLE;
          end
        end
        S_WHOLE: begin
          kind    <= scft_pkg::RES_WHOLE;
          state   <= S_EMIT;
        end
        S_WRAP: begin
          kind  <= scft_pkg::RES_TERM;
          state <= S_EMIT;
        end
        S_MUL_DA:    state <= S_SUB_M;
        S_SUB_M:     state <= S_MUL_MM;
        S_MUL_MM:    state <= S_DIV1_GO;
        S_DIV1_GO:   state <= S_DIV1_WAIT;
        S_DIV1_WAIT: begin
          if (stat.div_done) begin
            state <= S_DIV1_TAKE;
          end
        end
        S_DIV1_TAKE: begin
          if (stat.q_zero) begin
            kind  <= scft_pkg::RES_ERR;
            state <= S_EMIT;
          end else begin
            state <= S_DIV2_WAIT;
          end
        end
        S_DIV2_WAIT: begin
          if (stat.div_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          kind  <= scft_pkg::RES_TERM;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A new radicand restarts the expansion from its whole part.
      if (cfg_we) begin
        started <= 1'b0;
      end else if (state == S_WHOLE) begin
        started <= 1'b1;
      end
    end
  end

  `SCFT_ASSERT(a_emit_has_room, res.emit |-> out_free, "result emitted into a full output")
  `SCFT_ASSERT_NEVER(a_div_start_busy,
    (cmd.op == scft_pkg::OP_DIV1_GO || cmd.op == scft_pkg::OP_DIV2_GO) && stat.div_busy,
    "divider started while busy")
  `SCFT_ASSERT(a_accept_leaves_idle, accept |=> (state != S_IDLE), "item accepted but no work")

endmodule

// ----- hw/rtl/sqrt_continued_fraction_terms_unit.sv -----
// ----------------------------------------------------------------------------
// sqrt_continued_fraction_terms_unit
// Produces the continued-fraction terms of sqrt(radicand), one term per item.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                           Direction  Payload
//   config    cfg_we, cfg_data[31:0]            in         radicand
//   request   in_valid, in_ready, restart       in         restart
//   result    out_valid, out_ready, term,       out        term, is_whole_part,
//             is_whole_part, last_of_period,               last_of_period,
//             square_error                                 square_error
//
// A whole-part item (restart, or the first item after reset or after a radicand
// write) runs the 16-step digit-by-digit square root. A period term takes two
// multiplies, then two divisions on the shared radix-2 divider, 32 quotient bits
// for the new denominator and 18 for the term. A wrap to the first period term
// restores the stored first state, and a perfect square is answered with an
// error result. Reset is synchronous; it loads the radicand with 2 and marks
// the expansion as not started. A result waits in the output register while
// the next item is already taken and worked on; a stall there only holds the
// sequencer once its next result is ready.
//
module sqrt_continued_fraction_terms_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [scft_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scft_pkg::TERM_W-1:0]  term,
  output logic                         is_whole_part,
  output logic                         last_of_period,
  output logic                         square_error
);

  scft_pkg::dp_cmd_t  cmd;
  scft_pkg::dp_stat_t stat;
  scft_pkg::dp_view_t view;
  scft_pkg::ctl_res_t res;
  logic               out_free;

  // The output register can take a new result when it is empty or being read.
  assign out_free = !out_valid || out_ready;

  scft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .res      (res)
  );

  scft_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .view     (view)
  );

  // Output register. The sequencer names the kind of result, and the fields
  // are taken from the datapath state that the last step left behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      unique case (res.kind)
        scft_pkg::RES_WHOLE: begin
          // Whole part: the error flag tells whether the radicand is a square.
          term           <= scft_pkg::TERM_W'(view.root);
          is_whole_part  <= 1'b1;
          last_of_period <= 1'b0;
          square_error   <= view.sq;
        end
        scft_pkg::RES_TERM: begin
          // A period term closes the period when it leaves a denominator of one.
          term           <= scft_pkg::TERM_W'(view.last_term);
          is_whole_part  <= 1'b0;
          last_of_period <= view.d_one;
          square_error   <= 1'b0;
        end
        default: begin
          // Square radicand or a zero divisor: repeat the whole part as an error.
          term           <= scft_pkg::TERM_W'(view.root);
          is_whole_part  <= 1'b0;
          last_of_period <= 1'b0;
          square_error   <= 1'b1;
        end
      endcase
    end
  end

endmodule
